// ----- rtl/ehp_pkg.sv -----
// ehp_pkg: shared types, constants and helpers of the ethernet header parser
// no dependencies

package ehp_pkg;

  localparam int unsigned NumFields = 22;
  localparam int unsigned OffW      = 9;

  localparam logic [4:0]  LastTag   = 5'd21;

  localparam logic [15:0] EtIpv4    = 16'h0800;
  localparam logic [15:0] EtArp     = 16'h0806;
  localparam logic [15:0] EtCtag    = 16'h8100;
  localparam logic [15:0] EtStag    = 16'h88A8;
  localparam logic [15:0] EtIpv6    = 16'h86DD;

  localparam logic [7:0]  ProtoIcmp  = 8'd1;
  localparam logic [7:0]  ProtoTcp   = 8'd6;
  localparam logic [7:0]  ProtoUdp   = 8'd17;
  localparam logic [7:0]  ProtoIcmp6 = 8'd58;

  localparam logic [63:0] StatusOk    = 64'd0;
  localparam logic [63:0] StatusTrunc = 64'd1;
  localparam logic [63:0] StatusUnsup = 64'd2;

  typedef enum logic [4:0] {
    FldDmac, FldSmac, FldOvlan, FldIvlan, FldL3, FldIpVer, FldTtl,
    FldSrcHi, FldSrcLo, FldDstHi, FldDstLo, FldL4, FldPorts, FldTcpFlags,
    FldIcmp, FldArpOp, FldArpSha, FldArpSpa, FldArpTha, FldArpTpa,
    FldLength, FldStatus
  } fld_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  field_tag;
    logic [63:0] field_value;
    logic        last_of_frame;
  } out_item_t;

  // frame descriptor handed from capture to decode
  typedef struct packed {
    logic        valid;
    logic [15:0] len;
  } desc_t;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_RD_ISSUE, S_RD_TAKE,
    S_DMAC, S_SMAC, S_ET0, S_OTCI, S_OET, S_CHK_CTAG, S_ITCI, S_IET, S_CHK_L3,
    S_V4_TTL, S_V4_PROTO, S_V4_SRC, S_V4_DST, S_V4_IHL,
    S_V6_TTL, S_V6_PROTO, S_V6_S0, S_V6_S1, S_V6_D0, S_V6_D1,
    S_L4, S_PORTS, S_TFLAGS, S_ICMP,
    S_ARP_OP, S_ARP_SHA, S_ARP_SPA, S_EMIT
  } dec_state_e;

  function automatic logic fits(input logic [15:0] len, input logic [OffW-1:0] off,
                                input logic [6:0] need);
    return {1'b0, len} >= (17'(off) + 17'(need));
  endfunction

  function automatic logic [63:0] tci_val(input logic [15:0] tci);
    return {49'd0, tci[15:13], tci[11:0]};
  endfunction

endpackage

// ----- rtl/ehp_front.sv -----
// ehp_front: byte capture, frame length count and header store
// depends on ehp_pkg

module ehp_front #(
  parameter int unsigned HEADER_BYTES = 128
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  ehp_pkg::in_item_t        in_item_i,
  output logic                     full_o,
  output ehp_pkg::desc_t           desc_o,
  input  logic                     release_i,
  input  logic [ehp_pkg::OffW-1:0] rd_addr_i,
  output logic [7:0]               rd_data_o
);
  import ehp_pkg::*;

  localparam int unsigned AW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

  logic [7:0]  mem [HEADER_BYTES];
  logic [15:0] count_q, count_d, count_inc;
  logic        hold_q, hold_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  rd_data_q;
  logic        fire;

  assign fire      = push_i && !hold_q;
  assign count_inc = (count_q == 16'hFFFF) ? count_q : count_q + 16'd1;

  always_comb begin
    count_d = count_q;
    hold_d  = hold_q;
    len_d   = len_q;
    if (release_i) hold_d = 1'b0;
    if (fire) begin
      if (in_item_i.frame_end) begin
        count_d = '0;
        hold_d  = 1'b1;
        len_d   = count_inc;
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hold_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      hold_q  <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
  end

  always_ff @(posedge clk_i) begin
    if (fire && (count_q < 16'(HEADER_BYTES))) begin
      mem[count_q[AW-1:0]] <= in_item_i.data_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_addr_i < OffW'(HEADER_BYTES)) rd_data_q <= mem[rd_addr_i[AW-1:0]];
    else rd_data_q <= 8'd0;
  end

  assign full_o       = hold_q;
  assign desc_o.valid = hold_q;
  assign desc_o.len   = len_q;
  assign rd_data_o    = rd_data_q;

endmodule

// ----- rtl/ehp_back.sv -----
// ehp_back: header decode sequencer and field emission register
// depends on ehp_pkg, reads the header store of ehp_front

module ehp_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ehp_pkg::desc_t           desc_i,
  output logic                     release_o,
  output logic [ehp_pkg::OffW-1:0] rd_addr_o,
  input  logic [7:0]               rd_data_i,
  input  logic                     pop_i,
  output logic                     empty_o,
  output ehp_pkg::out_item_t       out_item_o
);
  import ehp_pkg::*;

  dec_state_e      state_q, state_d, ret_q, ret_d;
  logic [OffW-1:0] off_q, off_d, base_q, base_d;
  logic [3:0]      n_q, n_d, k_q, k_d;
  logic [63:0]     acc_q, acc_d;
  logic [15:0]     et_q, et_d, len_q, len_d;
  logic [7:0]      proto_q, proto_d;
  logic            ovid_q, ovid_d;
  logic [63:0]     fld_q [NumFields];
  logic [63:0]     fld_d [NumFields];
  logic [4:0]      idx_q, idx_d;
  out_item_t       out_q, out_d;
  logic            ovalid_q, ovalid_d;
  logic            load;

  assign load = (state_q == S_EMIT) && (!ovalid_q || pop_i);

  // next state and datapath
  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    off_d    = off_q;
    base_d   = base_q;
    n_d      = n_q;
    k_d      = k_q;
    acc_d    = acc_q;
    et_d     = et_q;
    len_d    = len_q;
    proto_d  = proto_q;
    ovid_d   = ovid_q;
    idx_d    = idx_q;
    fld_d    = fld_q;
    out_d    = out_q;
    ovalid_d = ovalid_q && !pop_i;
    case (state_q)
      S_IDLE: if (desc_i.valid) begin
        len_d   = desc_i.len;
        state_d = S_START;
      end
      S_START: begin
        for (int i = 0; i < NumFields; i++) fld_d[i] = '0;
        fld_d[FldLength] = {48'd0, len_q};
        off_d  = OffW'(14);
        ovid_d = 1'b0;
        idx_d  = '0;
        if (!fits(len_q, '0, 7'd14)) begin
          fld_d[FldStatus] = StatusTrunc;
          state_d = S_EMIT;
        end else begin
          base_d = '0; n_d = 4'd6; k_d = '0; acc_d = '0; ret_d = S_DMAC;
          state_d = S_RD_ISSUE;
        end
      end
      S_RD_ISSUE: state_d = S_RD_TAKE;
      S_RD_TAKE: begin
        acc_d = {acc_q[55:0], rd_data_i};
        if (k_q == n_q - 4'd1) state_d = ret_q;
        else begin
          k_d = k_q + 4'd1;
          state_d = S_RD_ISSUE;
        end
      end
      S_DMAC: begin
        fld_d[FldDmac] = acc_q;
        base_d = OffW'(6); n_d = 4'd6; k_d = '0; acc_d = '0; ret_d = S_SMAC;
        state_d = S_RD_ISSUE;
      end
      S_SMAC: begin
        fld_d[FldSmac] = acc_q;
        base_d = OffW'(12); n_d = 4'd2; k_d = '0; acc_d = '0; ret_d = S_ET0;
        state_d = S_RD_ISSUE;
      end
      S_ET0: begin
        et_d = acc_q[15:0];
        if (acc_q[15:0] == EtStag) begin
          if (!fits(len_q, off_q, 7'd4)) begin
            fld_d[FldStatus] = StatusTrunc;
            state_d = S_EMIT;
          end else begin
            base_d = off_q; n_d = 4'd2; k_d = '0; acc_d = '0; ret_d = S_OTCI;
            state_d = S_RD_ISSUE;
          end
        end else state_d = S_CHK_CTAG;
      end
      S_OTCI: begin
        fld_d[FldOvlan] = tci_val(acc_q[15:0]);
        ovid_d = (acc_q[11:0] != 12'd0);
        base_d = off_q + OffW'(2); n_d = 4'd2; k_d = '0; acc_d = '0; ret_d = S_OET;
        state_d = S_RD_ISSUE;
      end
      S_OET: begin
        et_d  = acc_q[15:0];
        off_d = off_q + OffW'(4);
        state_d = S_CHK_CTAG;
      end
      S_CHK_CTAG: begin
        if (et_q == EtCtag) begin
          if (!fits(len_q, off_q, 7'd4)) begin
            fld_d[FldStatus] = StatusTrunc;
            state_d = S_EMIT;
          end else begin
            base_d = off_q; n_d = 4'd2; k_d = '0; acc_d = '0; ret_d = S_ITCI;
            state_d = S_RD_ISSUE;
          end
        end else state_d = S_CHK_L3;
      end
      S_ITCI: begin
        if (ovid_q) fld_d[FldIvlan] = tci_val(acc_q[15:0]);
        else fld_d[FldOvlan] = tci_val(acc_q[15:0]);
        base_d = off_q + OffW'(2); n_d = 4'd2; k_d = '0; acc_d = '0; ret_d = S_IET;
        state_d = S_RD_ISSUE;
      end
      S_IET: begin
        et_d  = acc_q[15:0];
        off_d = off_q + OffW'(4);
        state_d = S_CHK_L3;
      end
      S_CHK_L3: begin
        k_d = '0; acc_d = '0;
        if (et_q == EtIpv4) begin
          fld_d[FldL3] = {48'd0, et_q};
          if (!fits(len_q, off_q, 7'd20)) begin
            fld_d[FldStatus] = StatusTrunc;
            state_d = S_EMIT;
          end else begin
            fld_d[FldIpVer] = 64'd4;
            base_d = off_q + OffW'(8); n_d = 4'd1; ret_d = S_V4_TTL;
            state_d = S_RD_ISSUE;
          end
        end else if (et_q == EtIpv6) begin
          fld_d[FldL3] = {48'd0, et_q};
          if (!fits(len_q, off_q, 7'd40)) begin
            fld_d[FldStatus] = StatusTrunc;
            state_d = S_EMIT;
          end else begin
            fld_d[FldIpVer] = 64'd6;
            base_d = off_q + OffW'(7); n_d = 4'd1; ret_d = S_V6_TTL;
            state_d = S_RD_ISSUE;
          end
        end else if (et_q == EtArp) begin
          fld_d[FldL3] = {48'd0, et_q};
          if (!fits(len_q, off_q, 7'd28)) begin
            fld_d[FldStatus] = StatusTrunc;
            state_d = S_EMIT;
          end else begin
            base_d = off_q + OffW'(6); n_d = 4'd2; ret_d = S_ARP_OP;
            state_d = S_RD_ISSUE;
          end
        end else begin
          fld_d[FldStatus] = StatusUnsup;
          state_d = S_EMIT;
        end
      end
      S_V4_TTL: begin
        fld_d[FldTtl] = acc_q;
        base_d = off_q + OffW'(9); n_d = 4'd1; k_d = '0; acc_d = '0; ret_d = S_V4_PROTO;
        state_d = S_RD_ISSUE;
      end
      S_V4_PROTO: begin
        proto_d = acc_q[7:0];
        base_d = off_q + OffW'(12); n_d = 4'd4; k_d = '0; acc_d = '0; ret_d = S_V4_SRC;
        state_d = S_RD_ISSUE;
      end
      S_V4_SRC: begin
        fld_d[FldSrcLo] = acc_q;
        base_d = off_q + OffW'(16); n_d = 4'd4; k_d = '0; acc_d = '0; ret_d = S_V4_DST;
        state_d = S_RD_ISSUE;
      end
      S_V4_DST: begin
        fld_d[FldDstLo] = acc_q;
        base_d = off_q; n_d = 4'd1; k_d = '0; acc_d = '0; ret_d = S_V4_IHL;
        state_d = S_RD_ISSUE;
      end
      S_V4_IHL: begin
        off_d = off_q + OffW'({acc_q[3:0], 2'b00});
        state_d = S_L4;
      end
      S_V6_TTL: begin
        fld_d[FldTtl] = acc_q;
        base_d = off_q + OffW'(6); n_d = 4'd1; k_d = '0; acc_d = '0; ret_d = S_V6_PROTO;
        state_d = S_RD_ISSUE;
      end
      S_V6_PROTO: begin
        proto_d = acc_q[7:0];
        base_d = off_q + OffW'(8); n_d = 4'd8; k_d = '0; acc_d = '0; ret_d = S_V6_S0;
        state_d = S_RD_ISSUE;
      end
      S_V6_S0: begin
        fld_d[FldSrcHi] = acc_q;
        base_d = off_q + OffW'(16); n_d = 4'd8; k_d = '0; acc_d = '0; ret_d = S_V6_S1;
        state_d = S_RD_ISSUE;
      end
      S_V6_S1: begin
        fld_d[FldSrcLo] = acc_q;
        base_d = off_q + OffW'(24); n_d = 4'd8; k_d = '0; acc_d = '0; ret_d = S_V6_D0;
        state_d = S_RD_ISSUE;
      end
      S_V6_D0: begin
        fld_d[FldDstHi] = acc_q;
        base_d = off_q + OffW'(32); n_d = 4'd8; k_d = '0; acc_d = '0; ret_d = S_V6_D1;
        state_d = S_RD_ISSUE;
      end
      S_V6_D1: begin
        fld_d[FldDstLo] = acc_q;
        off_d = off_q + OffW'(40);
        state_d = S_L4;
      end
      S_L4: begin
        base_d = off_q; k_d = '0; acc_d = '0;
        if (proto_q == ProtoTcp) begin
          if (!fits(len_q, off_q, 7'd20)) begin
            fld_d[FldStatus] = StatusTrunc;
            state_d = S_EMIT;
          end else begin
            n_d = 4'd4; ret_d = S_PORTS; state_d = S_RD_ISSUE;
          end
        end else if (proto_q == ProtoUdp) begin
          if (!fits(len_q, off_q, 7'd8)) begin
            fld_d[FldStatus] = StatusTrunc;
            state_d = S_EMIT;
          end else begin
            n_d = 4'd4; ret_d = S_PORTS; state_d = S_RD_ISSUE;
          end
        end else if (proto_q == ProtoIcmp || proto_q == ProtoIcmp6) begin
          if (!fits(len_q, off_q, 7'd8)) begin
            fld_d[FldStatus] = StatusTrunc;
            state_d = S_EMIT;
          end else begin
            n_d = 4'd2; ret_d = S_ICMP; state_d = S_RD_ISSUE;
          end
        end else begin
          fld_d[FldStatus] = StatusUnsup;
          state_d = S_EMIT;
        end
      end
      S_PORTS: begin
        fld_d[FldPorts] = acc_q;
        if (proto_q == ProtoTcp) begin
          base_d = off_q + OffW'(13); n_d = 4'd1; k_d = '0; acc_d = '0; ret_d = S_TFLAGS;
          state_d = S_RD_ISSUE;
        end else begin
          fld_d[FldL4] = {56'd0, proto_q};
          state_d = S_EMIT;
        end
      end
      S_TFLAGS: begin
        fld_d[FldTcpFlags] = acc_q;
        fld_d[FldL4] = {56'd0, proto_q};
        state_d = S_EMIT;
      end
      S_ICMP: begin
        fld_d[FldIcmp] = acc_q;
        fld_d[FldL4] = {56'd0, proto_q};
        state_d = S_EMIT;
      end
      S_ARP_OP: begin
        fld_d[FldArpOp] = acc_q;
        base_d = off_q + OffW'(8); n_d = 4'd6; k_d = '0; acc_d = '0; ret_d = S_ARP_SHA;
        state_d = S_RD_ISSUE;
      end
      S_ARP_SHA: begin
        // sender and target addresses follow in one 20-byte run
        fld_d[FldArpSha] = acc_q;
        base_d = off_q + OffW'(14); n_d = 4'd4; k_d = '0; acc_d = '0; ret_d = S_ARP_SPA;
        state_d = S_RD_ISSUE;
      end
      S_ARP_SPA: begin
        if (base_q == off_q + OffW'(14)) begin
          fld_d[FldArpSpa] = acc_q;
          base_d = off_q + OffW'(18); n_d = 4'd6; ret_d = S_ARP_SPA;
        end else if (base_q == off_q + OffW'(18)) begin
          fld_d[FldArpTha] = acc_q;
          base_d = off_q + OffW'(24); n_d = 4'd4; ret_d = S_ARP_SPA;
        end else begin
          fld_d[FldArpTpa] = acc_q;
        end
        k_d = '0; acc_d = '0;
        state_d = (base_q == off_q + OffW'(24)) ? S_EMIT : S_RD_ISSUE;
      end
      S_EMIT: if (load) begin
        out_d.field_tag     = idx_q;
        out_d.field_value   = fld_q[idx_q];
        out_d.last_of_frame = (idx_q == LastTag);
        ovalid_d = 1'b1;
        idx_d    = idx_q + 5'd1;
        if (idx_q == LastTag) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rd_addr_o  = base_q + OffW'(k_q);
    release_o  = (state_q != S_EMIT) && (state_d == S_EMIT);
    empty_o    = !ovalid_q;
    out_item_o = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q   <= ret_d;
    off_q   <= off_d;
    base_q  <= base_d;
    n_q     <= n_d;
    k_q     <= k_d;
    acc_q   <= acc_d;
    et_q    <= et_d;
    len_q   <= len_d;
    proto_q <= proto_d;
    ovid_q  <= ovid_d;
    idx_q   <= idx_d;
    fld_q   <= fld_d;
    out_q   <= out_d;
  end

endmodule

// ----- rtl/ethernet_header_parser_unit.sv -----
// ethernet_header_parser_unit: top level of the ethernet header parser
// depends on ehp_pkg, ehp_front, ehp_back

// Frame bytes are pushed one per beat in wire order, frame_end marking the
// last byte of each frame. The first HEADER_BYTES bytes go into the header
// store of the capture side and the length is counted, saturating at 65535.
// On the last byte the capture side hands a frame descriptor to the decode
// side and raises full until decode has finished reading the store; decode
// walks the headers one store byte at a time, an issue state and a take state
// per byte (one read port, registered data), then emits 22 field beats,
// one per cycle while pop is held. Field emission overlaps capture of the
// next frame. Bytes are taken one per cycle while full is low; the last byte
// of a frame holds the input off for its decode time, plus any wait for the
// previous frame's field beats to drain, since decode only starts once the
// last of them has entered the output register.
// Absent fields read as zero; status is 0 ok, 1 truncated, 2 unsupported,
// and last_of_frame marks the status beat.

module ethernet_header_parser_unit #(
  parameter int unsigned HEADER_BYTES = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  ehp_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output ehp_pkg::out_item_t out_item_o
);
  import ehp_pkg::*;

  desc_t           desc;
  logic            release_w;
  logic [OffW-1:0] rd_addr;
  logic [7:0]      rd_data;

  // capture side: header store and length counter
  ehp_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_item_i (in_item_i),
    .full_o    (full),
    .desc_o    (desc),
    .release_i (release_w),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // decode side: sequencer and output register
  ehp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .desc_i     (desc),
    .release_o  (release_w),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

  // the store is only handed back while a frame is held
  a_release_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    release_w |-> desc.valid) else $error("release without held frame");

  // the status beat alone closes a frame
  a_last_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.last_of_frame == (out_item_o.field_tag == LastTag)))
    else $error("last_of_frame off the status beat");

  // no field tag beyond the status
  a_tag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_item_o.field_tag <= LastTag) else $error("field tag out of range");

endmodule

// ----- tb/sv/ehp_field_checker.sv -----
// ehp_field_checker: watches the byte and field channels of the parser,
// predicts the field beats of each frame and compares them in order
// depends on ehp_pkg
`timescale 1ns / 1ps

module ehp_field_checker
  import ehp_pkg::*;
(
  input  logic      clk_i,
  input  logic      push,
  input  logic      full,
  input  in_item_t  in_item_i,
  input  logic      empty,
  input  logic      pop,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam int HdrBytes = 128;

  logic [7:0]  hdr_mem [HdrBytes];
  logic [15:0] frame_len;
  logic [63:0] fld [NumFields];
  out_item_t   field_q [$];

  initial begin
    fail_count_o = 0;
    frame_len    = '0;
  end

  assign pending_o = field_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  function automatic logic [63:0] rd(input int i);
    return (i < HdrBytes) ? 64'(hdr_mem[i]) : 64'd0;
  endfunction

  function automatic logic [63:0] be(input int off, input int n);
    logic [63:0] v;
    v = '0;
    for (int k = 0; k < n; k++) v = (v << 8) | rd(off + k);
    return v;
  endfunction

  function automatic bit room(input int len, input int off, input int need);
    return (len >= off) && ((len - off) >= need);
  endfunction

  function automatic logic [63:0] tci_fld(input logic [15:0] tci);
    return {49'd0, tci[15:13], tci[11:0]};
  endfunction

  function automatic logic [63:0] decode_l4(input int len, input int off, input logic [7:0] proto);
    if (proto == ProtoTcp) begin
      if (!room(len, off, 20)) return StatusTrunc;
      fld[FldPorts]    = be(off, 4);
      fld[FldTcpFlags] = rd(off + 13);
    end else if (proto == ProtoUdp) begin
      if (!room(len, off, 8)) return StatusTrunc;
      fld[FldPorts] = be(off, 4);
    end else if (proto == ProtoIcmp || proto == ProtoIcmp6) begin
      if (!room(len, off, 8)) return StatusTrunc;
      fld[FldIcmp] = be(off, 2);
    end else begin
      return StatusUnsup;
    end
    fld[FldL4] = 64'(proto);
    return StatusOk;
  endfunction

  function automatic logic [63:0] decode_hdr(input int len);
    int          off;
    logic [15:0] et;
    logic [15:0] tci;
    logic [11:0] ovid;
    logic [7:0]  proto;
    off  = 14;
    ovid = '0;
    if (!room(len, 0, 14)) return StatusTrunc;
    fld[FldDmac] = be(0, 6);
    fld[FldSmac] = be(6, 6);
    et = 16'(be(12, 2));
    if (et == EtStag) begin
      if (!room(len, off, 4)) return StatusTrunc;
      tci = 16'(be(off, 2));
      fld[FldOvlan] = tci_fld(tci);
      ovid = tci[11:0];
      et = 16'(be(off + 2, 2));
      off += 4;
    end
    if (et == EtCtag) begin
      if (!room(len, off, 4)) return StatusTrunc;
      tci = 16'(be(off, 2));
      // inner slot only behind a service tag with a real vid
      if (ovid != 0) fld[FldIvlan] = tci_fld(tci);
      else fld[FldOvlan] = tci_fld(tci);
      et = 16'(be(off + 2, 2));
      off += 4;
    end
    if (et == EtIpv4) begin
      fld[FldL3] = 64'(et);
      if (!room(len, off, 20)) return StatusTrunc;
      fld[FldIpVer] = 64'd4;
      fld[FldTtl]   = rd(off + 8);
      fld[FldSrcLo] = be(off + 12, 4);
      fld[FldDstLo] = be(off + 16, 4);
      proto = 8'(rd(off + 9));
      off += int'(rd(off) & 64'h0F) * 4;
      return decode_l4(len, off, proto);
    end
    if (et == EtIpv6) begin
      fld[FldL3] = 64'(et);
      if (!room(len, off, 40)) return StatusTrunc;
      fld[FldIpVer] = 64'd6;
      fld[FldTtl]   = rd(off + 7);
      proto = 8'(rd(off + 6));
      fld[FldSrcHi] = be(off + 8, 8);
      fld[FldSrcLo] = be(off + 16, 8);
      fld[FldDstHi] = be(off + 24, 8);
      fld[FldDstLo] = be(off + 32, 8);
      return decode_l4(len, off + 40, proto);
    end
    if (et == EtArp) begin
      fld[FldL3] = 64'(et);
      if (!room(len, off, 28)) return StatusTrunc;
      fld[FldArpOp]  = be(off + 6, 2);
      fld[FldArpSha] = be(off + 8, 6);
      fld[FldArpSpa] = be(off + 14, 4);
      fld[FldArpTha] = be(off + 18, 6);
      fld[FldArpTpa] = be(off + 24, 4);
      return StatusOk;
    end
    return StatusUnsup;
  endfunction

  // byte side: capture, count and decode at the frame end
  always @(posedge clk_i) begin
    out_item_t item;
    logic [63:0] st;
    if (push && !full) begin
      if (frame_len < HdrBytes) hdr_mem[frame_len] = in_item_i.data_byte;
      if (frame_len != 16'hFFFF) frame_len = frame_len + 16'd1;
      if (in_item_i.frame_end) begin
        for (int i = 0; i < NumFields; i++) fld[i] = '0;
        st = decode_hdr(int'(frame_len));
        fld[FldStatus] = st;
        fld[FldLength] = 64'(frame_len);
        for (int i = 0; i < NumFields; i++) begin
          item.field_tag     = 5'(i);
          item.field_value   = fld[i];
          item.last_of_frame = (5'(i) == LastTag);
          field_q.push_back(item);
        end
        frame_len = '0;
      end
    end
  end

  // field side: compare against the oldest expected beat
  always @(posedge clk_i) begin
    out_item_t want;
    if (pop && !empty) begin
      if (field_q.size() == 0) begin
        report("unexpected beat", 64'(out_item_i.field_tag), 64'd0);
      end else begin
        want = field_q.pop_front();
        if (out_item_i.field_tag != want.field_tag)
          report("field_tag", 64'(out_item_i.field_tag), 64'(want.field_tag));
        if (out_item_i.field_value != want.field_value)
          report("field_value", out_item_i.field_value, want.field_value);
        if (out_item_i.last_of_frame != want.last_of_frame)
          report("last_of_frame", 64'(out_item_i.last_of_frame), 64'(want.last_of_frame));
      end
    end
  end

endmodule

// ----- tb/sv/ethernet_header_parser_unit_test.sv -----
// ethernet_header_parser_unit_test: top of the parser testbench, builds frames,
// drives bytes and pops field beats, gives the verdict
// depends on ehp_pkg, ethernet_header_parser_unit, ehp_field_checker
`timescale 1ns / 1ps

module ethernet_header_parser_unit_test;
  import ehp_pkg::*;

  localparam int CycleLimit = 200000;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        cycles;
  bit        quiet;      // no idling in the last part of the run
  bit        hold_off;   // long receiver stall for back-pressure
  bit        all_sent;
  logic [7:0] frame_q [$];

  ethernet_header_parser_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  ehp_field_checker u_checker (
    .clk_i        (clk_i),
    .push         (push),
    .full         (full),
    .in_item_i    (in_item),
    .empty        (empty),
    .pop          (pop),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni   = 1'b0;
    push     = 1'b0;
    pop      = 1'b0;
    in_item  = '0;
    quiet    = 1'b0;
    hold_off = 1'b0;
    all_sent = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // frame building helpers
  task automatic put_bytes(input logic [63:0] v, input int n);
    for (int k = n - 1; k >= 0; k--) frame_q.push_back(v[k*8 +: 8]);
  endtask

  task automatic put_rand(input int n);
    repeat (n) frame_q.push_back(8'($urandom));
  endtask

  // random mac, sometimes all ones or all zeros
  function automatic logic [47:0] rand_mac();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  // tci with vid forced to zero now and then
  function automatic logic [15:0] rand_tci(input bit zero_vid);
    logic [15:0] t;
    t = 16'($urandom);
    if (zero_vid) t[11:0] = '0;
    return t;
  endfunction

  task automatic put_l4(input logic [7:0] proto);
    if (proto == ProtoTcp) put_rand(20);
    else if (proto == ProtoUdp || proto == ProtoIcmp || proto == ProtoIcmp6) put_rand(8);
    else put_rand($urandom_range(0, 8));
  endtask

  function automatic logic [7:0] rand_proto();
    case ($urandom_range(0, 4))
      0: return ProtoTcp;
      1: return ProtoUdp;
      2: return ProtoIcmp;
      3: return ProtoIcmp6;
      default: return 8'($urandom);
    endcase
  endfunction

  // builds one well-formed frame into frame_q, then maybe cuts it short
  task automatic build_frame(input bit allow_cut);
    logic [15:0] et;
    logic [7:0]  proto;
    logic [3:0]  ihl;
    int          cut;
    frame_q.delete();
    put_bytes(64'(rand_mac()), 6);
    put_bytes(64'(rand_mac()), 6);
    case ($urandom_range(0, 4))
      0: et = EtIpv6;
      1: et = EtArp;
      2: et = 16'($urandom);
      default: et = EtIpv4;
    endcase
    // tag stack: none, customer, service, service+customer, three deep
    case ($urandom_range(0, 5))
      1: begin
        put_bytes(64'(EtCtag), 2); put_bytes(64'(rand_tci($urandom_range(0, 3) == 0)), 2);
      end
      2: begin
        put_bytes(64'(EtStag), 2); put_bytes(64'(rand_tci($urandom_range(0, 3) == 0)), 2);
      end
      3: begin
        put_bytes(64'(EtStag), 2); put_bytes(64'(rand_tci($urandom_range(0, 2) == 0)), 2);
        put_bytes(64'(EtCtag), 2); put_bytes(64'(rand_tci(1'b0)), 2);
      end
      4: begin
        put_bytes(64'(EtStag), 2); put_bytes(64'(rand_tci(1'b0)), 2);
        put_bytes(64'(EtCtag), 2); put_bytes(64'(rand_tci(1'b0)), 2);
        put_bytes(64'(EtCtag), 2); put_bytes(64'(rand_tci(1'b0)), 2);
      end
      default: ;
    endcase
    put_bytes(64'(et), 2);
    if (et == EtIpv4) begin
      ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
      proto = rand_proto();
      frame_q.push_back({4'h4, ihl});
      put_rand(7);
      frame_q.push_back(8'($urandom));
      frame_q.push_back(proto);
      put_rand(10);
      if (ihl > 5) put_rand((ihl - 5) * 4);
      put_l4(proto);
    end else if (et == EtIpv6) begin
      proto = rand_proto();
      put_rand(6);
      frame_q.push_back(proto);
      put_rand(33);
      put_l4(proto);
    end else if (et == EtArp) begin
      put_rand(28);
    end else begin
      put_rand($urandom_range(0, 10));
    end
    put_rand($urandom_range(0, 4));
    if (allow_cut && $urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, frame_q.size());
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
  endtask

  // one byte beat, optionally after an idle burst
  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= in_item_t'{data_byte: b, frame_end: last};
    forever begin
      @(negedge clk_i);
      if (!full) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // stimulus
  initial begin
    int sent_bytes;
    int frames;
    sent_bytes = 0;
    frames     = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    // single-byte frame, truncated at the ethernet layer
    frame_q.delete();
    frame_q.push_back(8'hFF);
    send_frame();
    sent_bytes += frame_q.size();
    // bare ethernet with an unknown ethertype
    frame_q.delete();
    put_bytes('1, 6); put_bytes('0, 6); put_bytes(64'(16'h1234), 2);
    send_frame();
    sent_bytes += frame_q.size();
    // ipv4 with ihl below five and tcp, random bytes elsewhere
    frame_q.delete();
    put_bytes(64'(rand_mac()), 6); put_bytes(64'(rand_mac()), 6); put_bytes(64'(EtIpv4), 2);
    frame_q.push_back(8'h42); put_rand(8); frame_q.push_back(ProtoTcp); put_rand(30);
    send_frame();
    sent_bytes += frame_q.size();

    // random frames; receiver stalls long once while bytes keep coming
    while (sent_bytes < 200) begin
      build_frame(1'b1);
      if (frames == 1) hold_off = 1'b1;
      if (sent_bytes >= 160) quiet = 1'b1;
      send_frame();
      sent_bytes += frame_q.size();
      frames++;
    end
    push <= 1'b0;
    all_sent = 1'b1;
  end

  // field sink with random stall bursts
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        pop <= 1'b0;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 12);
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // verdict
  initial begin
    wait (all_sent);
    wait (pending == 0);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
